// ===== rtl/core/u8bmp_pkg.sv =====
// Package for the UTF-8 to 16-bit code unit decoder.
// Holds payload structs, status codes, counter width and the lead byte tables.
// No dependencies.
`default_nettype none

package u8bmp_pkg;

  // Width of the internal unit counter (8 to 32)
  localparam int CountWidth = 16;

  // Result status codes
  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusBadCont  = 3'd1;
  localparam logic [2:0] StatusOverlong = 3'd2;
  localparam logic [2:0] StatusBeyond   = 3'd3;
  localparam logic [2:0] StatusFull     = 3'd4;

  // Result kinds
  localparam logic KindUnit    = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] code_unit;
    logic [15:0] unit_count;
    logic [2:0]  status;
    logic        last_of_run;
  } out_item_t;

  // Number of continuation bytes announced by a lead byte, zero for none
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b < 8'hC0)      len = 3'd0;
    else if (b < 8'hE0) len = 3'd1;
    else if (b < 8'hF0) len = 3'd2;
    else if (b < 8'hF8) len = 3'd3;
    else if (b < 8'hFC) len = 3'd4;
    else if (b < 8'hFE) len = 3'd5;
    else                len = 3'd0;
    return len;
  endfunction

  // Payload bits kept from a lead byte
  function automatic logic [6:0] lead_mask(input logic [2:0] len);
    logic [6:0] m;
    case (len)
      3'd0:    m = 7'h7F;
      3'd1:    m = 7'h1F;
      3'd2:    m = 7'h0F;
      3'd3:    m = 7'h07;
      3'd4:    m = 7'h03;
      3'd5:    m = 7'h01;
      default: m = 7'h01;
    endcase
    return m;
  endfunction

  // Smallest value that is not overlong for a sequence class
  function automatic logic [30:0] min_value(input logic [2:0] cls);
    logic [30:0] v;
    case (cls)
      3'd0:    v = 31'h0;
      3'd1:    v = 31'h80;
      3'd2:    v = 31'h800;
      3'd3:    v = 31'h10000;
      3'd4:    v = 31'h200000;
      default: v = 31'h4000000;
    endcase
    return v;
  endfunction

  // Saturating increment of the unit counter
  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    logic [CountWidth-1:0] r;
    if (v == {CountWidth{1'b1}}) r = v;
    else                         r = v + 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utf8_to_bmp_decoder.sv =====
// Top level of the UTF-8 to 16-bit code unit decoder.
// Input register, single-pass decode logic and a four-entry result queue.
// Depends on u8bmp_pkg.
`default_nettype none

//  channel  | handshake          | payload     | direction
//  ---------+--------------------+-------------+----------
//  in       | in_valid/in_stall  | in_data     | into block
//  out      | out_valid/out_stall| out_data    | out of block
//  cfg      | cfg_we             | cfg_wdata   | into block
//
// One byte is accepted per cycle while in_stall is low; each byte is decoded from
// the input register, and its zero, one or two results enter the result queue.
// A result passes through the input register and the result queue before it
// raises out_valid, and it is taken at a rising edge where out_stall is low.
// The queue drains one result per cycle while out_stall is low, so input stalls
// only while the queue holds more than two results. Reset (rst, synchronous)
// clears the decode state, the queue and the capacity register.

module utf8_to_bmp_decoder
  import u8bmp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire in_item_t    in_data,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      out_item_t   out_data,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  // Configuration
  logic [15:0] unit_capacity;

  // Input register
  logic     in_full;
  in_item_t in_q;

  // Decode state
  logic [2:0]            bytes_remaining, bytes_remaining_next;
  logic [2:0]            sequence_class, sequence_class_next;
  logic [30:0]           value_accumulator, value_accumulator_next;
  logic [CountWidth-1:0] units_done, units_done_next;
  logic [2:0]            error_code, error_code_next;

  // Result queue
  out_item_t        queue [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QPtrW:0]   q_count;

  // Decode outputs
  out_item_t   res0, res1;
  logic [1:0]  n_push;
  logic        advance;
  logic        pop;
  logic [30:0] acc_shift;
  logic [2:0]  len;
  logic [2:0]  br_dec;
  logic [2:0]  cls;
  logic [31:0] count_wide;
  logic [15:0] count_field;
  out_item_t   unit_res;
  out_item_t   summary_res;
  logic        emit_unit;

  assign advance   = in_full && (q_count <= (QPtrW+1)'(QDepth - 2));
  assign in_stall  = in_full && !advance;
  assign pop       = out_valid && !out_stall;
  assign out_valid = (q_count != '0);
  assign out_data  = queue[rd_ptr];

  // Capture configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_capacity <= '0;
    end else if (cfg_we) begin
      unit_capacity <= cfg_wdata;
    end
  end

  // Hold the next input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  // Decode the registered byte
  always_comb begin
    bytes_remaining_next   = bytes_remaining;
    sequence_class_next    = sequence_class;
    value_accumulator_next = value_accumulator;
    units_done_next        = units_done;
    error_code_next        = error_code;
    emit_unit              = 1'b0;
    unit_res               = '0;
    unit_res.kind          = KindUnit;
    summary_res            = '0;
    len                    = lead_len(in_q.data_byte);
    br_dec                 = bytes_remaining - 3'd1;
    acc_shift              = {value_accumulator[24:0], in_q.data_byte[5:0]};
    cls                    = (sequence_class > 3'd5) ? 3'd5 : sequence_class;

    if (unit_capacity == '0) begin
      // Count mode: lenient, no values
      if (bytes_remaining != 3'd0) begin
        if (in_q.data_byte[7:6] == 2'b10) begin
          bytes_remaining_next = br_dec;
          if (br_dec == 3'd0) begin
            units_done_next = sat_inc(units_done);
          end
        end else begin
          // End the open character, then start a new one
          bytes_remaining_next = 3'd0;
          units_done_next      = sat_inc(units_done);
          if (len == 3'd0) begin
            units_done_next = sat_inc(units_done_next);
          end else begin
            bytes_remaining_next = len;
            sequence_class_next  = len;
          end
        end
      end else if (len == 3'd0) begin
        units_done_next = sat_inc(units_done);
      end else begin
        bytes_remaining_next = len;
        sequence_class_next  = len;
      end
    end else if (error_code == StatusOk) begin
      if (bytes_remaining != 3'd0) begin
        if (in_q.data_byte[7:6] != 2'b10) begin
          error_code_next = StatusBadCont;
        end else begin
          value_accumulator_next = acc_shift;
          bytes_remaining_next   = br_dec;
          if (br_dec == 3'd0) begin
            if (acc_shift < min_value(cls)) begin
              error_code_next = StatusOverlong;
            end else if (acc_shift >= 31'h10000) begin
              error_code_next = StatusBeyond;
            end else begin
              emit_unit          = 1'b1;
              unit_res.code_unit = acc_shift[15:0];
              units_done_next    = sat_inc(units_done);
            end
          end
        end
      end else if (32'(units_done) >= 32'(unit_capacity)) begin
        error_code_next = StatusFull;
      end else if (len == 3'd0) begin
        // Plain ASCII or stray byte: low seven bits
        emit_unit          = 1'b1;
        unit_res.code_unit = {9'd0, in_q.data_byte[6:0]};
        units_done_next    = sat_inc(units_done);
      end else begin
        value_accumulator_next = {24'd0, in_q.data_byte[6:0] & lead_mask(len)};
        bytes_remaining_next   = len;
        sequence_class_next    = len;
      end
    end

    // Build the summary from the updated state
    count_wide  = (error_code_next == StatusOk) ? 32'(units_done_next) : 32'd0;
    count_field = (count_wide > 32'hFFFF) ? 16'hFFFF : count_wide[15:0];
    summary_res.kind        = KindSummary;
    summary_res.unit_count  = count_field;
    summary_res.status      = error_code_next;
    summary_res.last_of_run = 1'b1;

    if (in_q.end_of_string) begin
      bytes_remaining_next   = 3'd0;
      sequence_class_next    = 3'd0;
      value_accumulator_next = '0;
      units_done_next        = '0;
      error_code_next        = StatusOk;
    end

    // Order the results for the queue
    if (emit_unit) begin
      res0 = unit_res;
      res1 = summary_res;
    end else begin
      res0 = summary_res;
      res1 = summary_res;
    end
    n_push = 2'(emit_unit) + 2'(in_q.end_of_string);
  end

  // Advance decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining   <= '0;
      sequence_class    <= '0;
      value_accumulator <= '0;
      units_done        <= '0;
      error_code        <= StatusOk;
    end else if (advance) begin
      bytes_remaining   <= bytes_remaining_next;
      sequence_class    <= sequence_class_next;
      value_accumulator <= value_accumulator_next;
      units_done        <= units_done_next;
      error_code        <= error_code_next;
    end
  end

  // Write results into the queue
  always_ff @(posedge clk) begin
    if (advance && n_push != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (advance && n_push == 2'd2) begin
      queue[wr_ptr + 1'b1] <= res1;
    end
  end

  // Track queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (advance) begin
        wr_ptr <= wr_ptr + QPtrW'(n_push);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      q_count <= q_count + (advance ? (QPtrW+1)'(n_push) : '0) - (QPtrW+1)'(pop);
    end
  end

endmodule

`default_nettype wire
